// File: rtl/tpl_pkg.sv
// Shared types and constants for the timed pulsing PWM LED cue controller.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package tpl_pkg;

    localparam logic [18:0] HALF_NUM = 19'd500000;
    localparam int          MAX_RES  = 3;

    // request codes on req_type
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_START    = 3'd1;
    localparam logic [2:0] REQ_STOP     = 3'd2;
    localparam logic [2:0] REQ_STOP_ALL = 3'd3;
    localparam logic [2:0] REQ_UPDATE   = 3'd4;

    // status codes
    localparam logic [2:0] ST_ACK     = 3'd0;
    localparam logic [2:0] ST_BAD_CH  = 3'd1;
    localparam logic [2:0] ST_BAD_DUR = 3'd2;
    localparam logic [2:0] ST_BAD_HZ  = 3'd3;
    localparam logic [2:0] ST_LED_ON  = 3'd4;
    localparam logic [2:0] ST_LED_OFF = 3'd5;

    // configuration register indexes
    localparam logic CFG_MAX_DUR = 1'b0;
    localparam logic CFG_MAX_HZ  = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  channel;
        logic [31:0] duration_ms;
        logic        pulse_enable;
        logic [15:0] pulse_hz;
        logic [7:0]  brightness;
        logic [31:0] now_ms;
        logic [31:0] now_us;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  event_channel;
        logic [7:0]  event_level;
        logic [15:0] event_hz;
        logic [31:0] event_time_ms;
        logic [2:0]  pin_levels;
        logic [2:0]  active_mask;
        logic        last;
    } out_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_TICK,
        OP_START,
        OP_ERR_CH,
        OP_ERR_DUR,
        OP_ERR_HZ,
        OP_STOP,
        OP_STOP_ALL,
        OP_UPDATE
    } op_t;

    typedef struct packed {
        op_t op;
        in_t req;
    } item_t;

endpackage

// File: rtl/tpl_front.sv
// Front end: accepts request words, classifies them and queues them for the back end.
// Depends on tpl_pkg.
module tpl_front #(
    parameter int CHANNELS = 3
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tpl_pkg::in_t  s_data,
    input  logic [31:0]   max_dur,
    input  logic [15:0]   max_hz,
    output logic          q_valid,
    output tpl_pkg::item_t q_item,
    input  logic          q_pop
);

    localparam int DEPTH = 2;

    tpl_pkg::item_t mem_reg [DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    tpl_pkg::item_t cls;
    logic           push, pop;

    always_comb begin
        cls.req = s_data;
        case (s_data.req_type)
            tpl_pkg::REQ_TICK: cls.op = tpl_pkg::OP_TICK;
            tpl_pkg::REQ_START: begin
                if (32'(s_data.channel) >= CHANNELS)
                    cls.op = tpl_pkg::OP_ERR_CH;
                else if (s_data.duration_ms > max_dur)
                    cls.op = tpl_pkg::OP_ERR_DUR;
                else if (s_data.pulse_enable &&
                         (s_data.pulse_hz == 16'd0 || s_data.pulse_hz > max_hz))
                    cls.op = tpl_pkg::OP_ERR_HZ;
                else
                    cls.op = tpl_pkg::OP_START;
            end
            tpl_pkg::REQ_STOP:     cls.op = tpl_pkg::OP_STOP;
            tpl_pkg::REQ_STOP_ALL: cls.op = tpl_pkg::OP_STOP_ALL;
            tpl_pkg::REQ_UPDATE:   cls.op = tpl_pkg::OP_UPDATE;
            default:               cls.op = tpl_pkg::OP_NOP;
        endcase
    end

    assign s_ready = (cnt_reg != 2'(DEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// File: rtl/tpl_div.sv
// Restoring divider for the half period: 500000 / hz, one quotient bit per cycle.
// Depends on tpl_pkg.
module tpl_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [18:0] quotient
);

    logic [18:0] q_reg, q_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[18]};
        if (start) begin
            q_next    = tpl_pkg::HALF_NUM;
            rem_next  = 16'd0;
            dsr_next  = divisor;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // dividend bits shift out the top while quotient bits shift in below
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = 16'(trial - {1'b0, dsr_reg});
                q_next   = {q_reg[17:0], 1'b1};
            end else begin
                rem_next = trial[15:0];
                q_next   = {q_reg[17:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd18) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: rtl/tpl_back.sv
// Back end: executes queued requests against the PWM and cue state, drives result words.
// Depends on tpl_pkg and tpl_div.
module tpl_back #(
    parameter int CHANNELS = 3,
    parameter int PWM_BITS = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  tpl_pkg::item_t q_item,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output tpl_pkg::out_t  m_data
);

    localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int KW  = $clog2(CHANNELS + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_DIV   = 5'b00100,
        S_CHAN  = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t         state_reg, state_next;
    tpl_pkg::item_t item_reg, item_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           held_valid_reg, held_valid_next;
    tpl_pkg::out_t  held_reg, held_next;
    logic           out_valid_reg, out_valid_next;
    tpl_pkg::out_t  out_reg, out_next;

    logic [PWM_BITS-1:0] pwm_reg, pwm_next;
    logic [CHANNELS-1:0] pin_reg, pin_next;
    logic [CHANNELS-1:0] act_reg, act_next;
    logic [7:0]  duty_reg [CHANNELS];
    logic [7:0]  duty_next [CHANNELS];
    logic [7:0]  bright_reg [CHANNELS];
    logic [7:0]  bright_next [CHANNELS];
    logic        puls_reg [CHANNELS];
    logic        puls_next [CHANNELS];
    logic [31:0] start_reg [CHANNELS];
    logic [31:0] start_next [CHANNELS];
    logic [31:0] dur_reg [CHANNELS];
    logic [31:0] dur_next [CHANNELS];
    logic [18:0] half_reg [CHANNELS];
    logic [18:0] half_next [CHANNELS];
    logic [31:0] tog_reg [CHANNELS];
    logic [31:0] tog_next [CHANNELS];
    logic        phase_reg [CHANNELS];
    logic        phase_next [CHANNELS];

    logic          div_start, div_done;
    logic [18:0]   div_q;
    logic          out_free;
    logic          ev_want, ev_emit;
    tpl_pkg::out_t ev;
    logic [CIW-1:0] ci, kc;
    logic [7:0]    pin8, act8;
    logic [31:0]   n1;
    logic          ph;
    tpl_pkg::in_t  rq;

    tpl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (item_reg.req.pulse_hz),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign rq       = item_reg.req;
    assign ci       = CIW'(rq.channel);
    assign kc       = k_reg[CIW-1:0];

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        out_valid_next  = (out_valid_reg && m_ready) ? 1'b0 : out_valid_reg;
        out_next        = out_reg;
        pwm_next        = pwm_reg;
        pin_next        = pin_reg;
        act_next        = act_reg;
        duty_next       = duty_reg;
        bright_next     = bright_reg;
        puls_next       = puls_reg;
        start_next      = start_reg;
        dur_next        = dur_reg;
        half_next       = half_reg;
        tog_next        = tog_reg;
        phase_next      = phase_reg;
        q_pop           = 1'b0;
        div_start       = 1'b0;
        ev_want         = 1'b0;
        ev_emit         = 1'b0;
        ev              = '0;
        n1              = '0;
        ph              = 1'b0;
        pin8            = '0;
        act8            = '0;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    cnt_next   = 2'd0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_FLUSH;
                case (item_reg.op)
                    tpl_pkg::OP_TICK: begin
                        pwm_next = pwm_reg + 1'b1;
                        for (int k = 0; k < CHANNELS; k++) begin
                            if (pwm_reg == '0 && duty_reg[k] != 8'd0) pin_next[k] = 1'b1;
                            if (16'(pwm_reg) == 16'(duty_reg[k])) pin_next[k] = 1'b0;
                        end
                    end
                    tpl_pkg::OP_ERR_CH: begin
                        ev_emit          = 1'b1;
                        ev.status        = tpl_pkg::ST_BAD_CH;
                        ev.event_channel = rq.channel;
                        ev.event_time_ms = rq.now_ms;
                    end
                    tpl_pkg::OP_ERR_DUR: begin
                        ev_emit          = 1'b1;
                        ev.status        = tpl_pkg::ST_BAD_DUR;
                        ev.event_channel = rq.channel;
                        ev.event_time_ms = rq.now_ms;
                    end
                    tpl_pkg::OP_ERR_HZ: begin
                        ev_emit          = 1'b1;
                        ev.status        = tpl_pkg::ST_BAD_HZ;
                        ev.event_channel = rq.channel;
                        ev.event_time_ms = rq.now_ms;
                    end
                    tpl_pkg::OP_START: begin
                        if (rq.pulse_enable) begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end else begin
                            half_next[ci] = '0;
                        end
                    end
                    tpl_pkg::OP_STOP: begin
                        if (32'(rq.channel) < CHANNELS && act_reg[ci]) begin
                            act_next[ci]     = 1'b0;
                            duty_next[ci]    = 8'd0;
                            ev_emit          = 1'b1;
                            ev.status        = tpl_pkg::ST_LED_OFF;
                            ev.event_channel = 2'(rq.channel);
                            ev.event_time_ms = rq.now_ms;
                        end
                    end
                    tpl_pkg::OP_STOP_ALL, tpl_pkg::OP_UPDATE: begin
                        k_next     = '0;
                        state_next = S_CHAN;
                    end
                    default: ;
                endcase
                // steady start applies here, pulsing start after the divide
                if (item_reg.op == tpl_pkg::OP_START && !rq.pulse_enable) begin
                    act_next[ci]     = 1'b1;
                    bright_next[ci]  = rq.brightness;
                    puls_next[ci]    = 1'b0;
                    start_next[ci]   = rq.now_ms;
                    dur_next[ci]     = rq.duration_ms;
                    phase_next[ci]   = 1'b1;
                    duty_next[ci]    = rq.brightness;
                    ev_emit          = 1'b1;
                    ev.status        = tpl_pkg::ST_LED_ON;
                    ev.event_channel = rq.channel;
                    ev.event_level   = rq.brightness;
                    ev.event_time_ms = rq.now_ms;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    act_next[ci]     = 1'b1;
                    bright_next[ci]  = rq.brightness;
                    puls_next[ci]    = 1'b1;
                    start_next[ci]   = rq.now_ms;
                    dur_next[ci]     = rq.duration_ms;
                    phase_next[ci]   = 1'b1;
                    half_next[ci]    = div_q;
                    tog_next[ci]     = rq.now_us + 32'(div_q);
                    duty_next[ci]    = rq.brightness;
                    ev_emit          = 1'b1;
                    ev.status        = tpl_pkg::ST_LED_ON;
                    ev.event_channel = rq.channel;
                    ev.event_level   = rq.brightness;
                    ev.event_hz      = rq.pulse_hz;
                    ev.event_time_ms = rq.now_ms;
                    state_next       = S_FLUSH;
                end
            end
            S_CHAN: begin
                // one channel per cycle unless held for the output; a stop or expiry becomes an off event
                if (act_reg[kc]) begin
                    if (item_reg.op == tpl_pkg::OP_STOP_ALL) begin
                        ev_want = 1'b1;
                    end else if (dur_reg[kc] != 32'd0 &&
                                 (rq.now_ms - start_reg[kc]) >= dur_reg[kc]) begin
                        ev_want = 1'b1;
                    end
                end
                if (ev_want && cnt_reg < 2'(tpl_pkg::MAX_RES) && held_valid_reg && !out_free) begin
                    // hold here until the pending word can move to the output
                end else begin
                    if (ev_want) begin
                        act_next[kc]  = 1'b0;
                        duty_next[kc] = 8'd0;
                        if (cnt_reg < 2'(tpl_pkg::MAX_RES)) begin
                            ev_emit          = 1'b1;
                            ev.status        = tpl_pkg::ST_LED_OFF;
                            ev.event_channel = 2'(kc);
                            ev.event_time_ms = rq.now_ms;
                        end
                    end else if (item_reg.op == tpl_pkg::OP_UPDATE && act_reg[kc] &&
                                 puls_reg[kc] &&
                                 ((rq.now_us - tog_reg[kc]) >> 31) == 32'd0) begin
                        ph             = !phase_reg[kc];
                        phase_next[kc] = ph;
                        duty_next[kc]  = ph ? bright_reg[kc] : 8'd0;
                        n1             = tog_reg[kc] + 32'(half_reg[kc]);
                        // resync when a whole half period was missed
                        if (((rq.now_us - n1) >> 31) == 32'd0)
                            tog_next[kc] = rq.now_us + 32'(half_reg[kc]);
                        else
                            tog_next[kc] = n1;
                    end
                    k_next = k_reg + 1'b1;
                    if (k_reg == KW'(CHANNELS - 1)) state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (held_valid_reg) begin
                        out_next      = held_reg;
                    end else begin
                        out_next             = '0;
                        pin8                 = 8'(pin_reg);
                        act8                 = 8'(act_reg);
                        out_next.pin_levels  = pin8[2:0];
                        out_next.active_mask = act8[2:0];
                    end
                    out_next.last   = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (ev_emit) begin
            pin8           = 8'(pin_next);
            act8           = 8'(act_next);
            ev.pin_levels  = pin8[2:0];
            ev.active_mask = act8[2:0];
            ev.last        = 1'b0;
            if (held_valid_reg) begin
                out_next       = held_reg;
                out_valid_next = 1'b1;
            end
            held_next       = ev;
            held_valid_next = 1'b1;
            cnt_next        = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            k_reg          <= '0;
            cnt_reg        <= 2'd0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pwm_reg        <= '0;
            pin_reg        <= '0;
            act_reg        <= '0;
            for (int k = 0; k < CHANNELS; k++) duty_reg[k] <= 8'd0;
        end else begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            cnt_reg        <= cnt_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
            pwm_reg        <= pwm_next;
            pin_reg        <= pin_next;
            act_reg        <= act_next;
            duty_reg       <= duty_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        held_reg   <= held_next;
        out_reg    <= out_next;
        bright_reg <= bright_next;
        puls_reg   <= puls_next;
        start_reg  <= start_next;
        dur_reg    <= dur_next;
        half_reg   <= half_next;
        tog_reg    <= tog_next;
        phase_reg  <= phase_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/timed_pulsing_pwm_led_cues.sv
// Top level of the timed pulsing PWM LED cue controller: config registers,
// request queue front end and execution back end. Depends on tpl_pkg, tpl_front, tpl_back.
//
//  channel  | ports                                   | word
//  ---------+-----------------------------------------+-------------------
//  request  | s_valid  s_ready  s_data                | tpl_pkg::in_t
//  result   | m_valid  m_ready  m_data                | tpl_pkg::out_t
//  config   | cfg_valid cfg_ready cfg_index cfg_data  | index + 32-bit data
//
// A two-word queue sits between front and back. Tick, stop and error requests
// pass through the back end's exec and flush states; a pulsing start waits on
// the 19-step half-period divider; stop-all and update visit each channel in turn.
// Reset (aresetn low, synchronous) clears PWM count, pins, duties and cues.
// A stalled m_ready holds the back end only when a further result word is due.
module timed_pulsing_pwm_led_cues #(
    parameter int CHANNELS = 3,
    parameter int PWM_BITS = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tpl_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output tpl_pkg::out_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data
);

    logic [31:0]    max_dur_reg;
    logic [15:0]    max_hz_reg;
    logic           q_valid, q_pop;
    tpl_pkg::item_t q_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_dur_reg <= 32'd3600000;
            max_hz_reg  <= 16'd50;
        end else if (cfg_valid) begin
            case (cfg_index)
                tpl_pkg::CFG_MAX_DUR: max_dur_reg <= cfg_data;
                tpl_pkg::CFG_MAX_HZ:  max_hz_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    tpl_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .max_dur (max_dur_reg),
        .max_hz  (max_hz_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    tpl_back #(
        .CHANNELS (CHANNELS),
        .PWM_BITS (PWM_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: tb/tb_timed_pulsing_pwm_led_cues.sv
// Self-checking testbench for timed_pulsing_pwm_led_cues: directed table plus random words,
// every result checked against a behavioral LED cue predictor. Depends on tpl_pkg and the RTL.
module tb_timed_pulsing_pwm_led_cues;
    import tpl_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    always #6 aclk = ~aclk;

    timed_pulsing_pwm_led_cues u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [31:0] lim_dur;
    logic [15:0] lim_hz;
    logic [7:0]  pwm_cnt;
    logic [2:0]  pins;
    logic [7:0]  duty [3];
    logic [2:0]  active;
    logic [7:0]  c_bright [3];
    logic        c_pulse [3];
    logic [31:0] c_start [3];
    logic [31:0] c_dur [3];
    logic [31:0] c_half [3];
    logic [31:0] c_next [3];
    logic        c_phase [3];

    out_t led_events [$];
    out_t step_events [$];
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_on = 0;
    int n_off = 0;

    function automatic void push_event(logic [2:0] st, logic [1:0] ch, logic [7:0] lvl,
                                       logic [15:0] hz, logic [31:0] t);
        out_t r;
        if (step_events.size() >= MAX_RES) return;
        r.status = st; r.event_channel = ch; r.event_level = lvl; r.event_hz = hz;
        r.event_time_ms = t; r.pin_levels = pins; r.active_mask = active; r.last = 1'b0;
        step_events.push_back(r);
    endfunction

    function automatic void cue_off(int k, logic [31:0] t);
        if (!active[k]) return;
        active[k] = 1'b0;
        duty[k] = '0;
        push_event(ST_LED_OFF, k[1:0], 8'd0, 16'd0, t);
    endfunction

    function automatic void predict_led(in_t w);
        logic [7:0] c;
        step_events.delete();
        case (w.req_type)
            REQ_TICK: begin
                c = pwm_cnt;
                pwm_cnt = pwm_cnt + 8'd1;
                for (int k = 0; k < 3; k++) begin
                    if (c == 0 && duty[k] != 0) pins[k] = 1'b1;
                    if (c == duty[k]) pins[k] = 1'b0;
                end
            end
            REQ_START: begin
                if (w.channel == 2'd3)
                    push_event(ST_BAD_CH, w.channel, 8'd0, 16'd0, w.now_ms);
                else if (w.duration_ms > lim_dur)
                    push_event(ST_BAD_DUR, w.channel, 8'd0, 16'd0, w.now_ms);
                else if (w.pulse_enable && (w.pulse_hz == 0 || w.pulse_hz > lim_hz))
                    push_event(ST_BAD_HZ, w.channel, 8'd0, 16'd0, w.now_ms);
                else begin
                    active[w.channel] = 1'b1;
                    c_bright[w.channel] = w.brightness;
                    c_pulse[w.channel] = w.pulse_enable;
                    c_start[w.channel] = w.now_ms;
                    c_dur[w.channel] = w.duration_ms;
                    c_phase[w.channel] = 1'b1;
                    if (w.pulse_enable) begin
                        c_half[w.channel] = 32'd500000 / w.pulse_hz;
                        c_next[w.channel] = w.now_us + c_half[w.channel];
                    end else
                        c_half[w.channel] = '0;
                    duty[w.channel] = w.brightness;
                    push_event(ST_LED_ON, w.channel, w.brightness,
                               w.pulse_enable ? w.pulse_hz : 16'd0, w.now_ms);
                end
            end
            REQ_STOP: if (w.channel != 2'd3) cue_off(int'(w.channel), w.now_ms);
            REQ_STOP_ALL: for (int k = 0; k < 3; k++) cue_off(k, w.now_ms);
            REQ_UPDATE: begin
                for (int k = 0; k < 3; k++) begin
                    if (!active[k]) continue;
                    if (c_dur[k] > 0 && (w.now_ms - c_start[k]) >= c_dur[k]) begin
                        cue_off(k, w.now_ms);
                        continue;
                    end
                    if (c_pulse[k] && !((w.now_us - c_next[k]) >> 31)) begin
                        c_phase[k] = !c_phase[k];
                        duty[k] = c_phase[k] ? c_bright[k] : 8'd0;
                        c_next[k] = c_next[k] + c_half[k];
                        if (!((w.now_us - c_next[k]) >> 31))
                            c_next[k] = w.now_us + c_half[k];
                    end
                end
            end
            default: ;
        endcase
        if (step_events.size() == 0) push_event(ST_ACK, 2'd0, 8'd0, 16'd0, 32'd0);
        step_events[step_events.size() - 1].last = 1'b1;
        foreach (step_events[i]) led_events.push_back(step_events[i]);
    endfunction

    // result side: random stalls, check against oldest expectation
    always @(posedge aclk) begin
        out_t e;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_results++;
                if (led_events.size() == 0) begin
                    $error("unexpected result word %h", m_data);
                    errors++;
                end else begin
                    e = led_events.pop_front();
                    if (e.status == ST_LED_ON) n_on++;
                    if (e.status == ST_LED_OFF) n_off++;
                    if (m_data.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, m_data.status); errors++;
                    end
                    if (m_data.event_channel !== e.event_channel) begin
                        $error("event_channel exp %0d got %0d", e.event_channel,
                               m_data.event_channel); errors++;
                    end
                    if (m_data.event_level !== e.event_level) begin
                        $error("event_level exp %0d got %0d", e.event_level,
                               m_data.event_level); errors++;
                    end
                    if (m_data.event_hz !== e.event_hz) begin
                        $error("event_hz exp %0d got %0d", e.event_hz, m_data.event_hz);
                        errors++;
                    end
                    if (m_data.event_time_ms !== e.event_time_ms) begin
                        $error("event_time_ms exp %0h got %0h", e.event_time_ms,
                               m_data.event_time_ms); errors++;
                    end
                    if (m_data.pin_levels !== e.pin_levels) begin
                        $error("pin_levels exp %b got %b", e.pin_levels, m_data.pin_levels);
                        errors++;
                    end
                    if (m_data.active_mask !== e.active_mask) begin
                        $error("active_mask exp %b got %b", e.active_mask,
                               m_data.active_mask); errors++;
                    end
                    if (m_data.last !== e.last) begin
                        $error("last exp %b got %b", e.last, m_data.last); errors++;
                    end
                end
            end
            if ($urandom_range(0, 3) == 0) m_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 : 1'b1;
            else if (!m_ready && $urandom_range(0, 2) == 0) m_ready <= 1'b1;
            else if (m_ready && $urandom_range(0, 9) == 0) m_ready <= 1'b0;
        end
    end

    function automatic int gap_len();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
            (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3));
        return n;
    endfunction

    // valid stays up into the next word when no gap follows
    task automatic send_word(in_t w);
        int n;
        s_data <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_led(w);
        n_items++;
        n = ($urandom_range(0, 2) != 0) ? gap_len() : 0;
        if (n != 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic hold_off();
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        hold_off();
        while (led_events.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_DUR) lim_dur = val;
        else lim_hz = val[15:0];
    endtask

    function automatic in_t mk(logic [2:0] rt, logic [1:0] ch, logic [31:0] dur, logic pe,
                               logic [15:0] hz, logic [7:0] br, logic [31:0] ms,
                               logic [31:0] us);
        in_t w;
        w.req_type = rt; w.channel = ch; w.duration_ms = dur; w.pulse_enable = pe;
        w.pulse_hz = hz; w.brightness = br; w.now_ms = ms; w.now_us = us;
        return w;
    endfunction

    // random word biased toward well-formed cues near current time
    logic [31:0] t_ms, t_us;
    function automatic in_t rand_word();
        in_t w;
        int sel;
        w = mk(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), $urandom(),
               1'($urandom_range(0, 1)), 16'($urandom()), 8'($urandom()), $urandom(),
               $urandom());
        sel = $urandom_range(0, 99);
        if (sel < 90) begin
            t_ms = t_ms + $urandom_range(0, 300);
            t_us = t_us + $urandom_range(0, 300000);
            w.now_ms = t_ms;
            w.now_us = t_us;
            if (sel < 40) w.req_type = REQ_TICK;
            else if (sel < 60) begin
                w.req_type = REQ_START;
                w.channel = 2'($urandom_range(0, 2));
                w.duration_ms = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 3000);
                w.pulse_hz = 16'($urandom_range(0, lim_hz > 60 ? 60 : lim_hz + 1));
            end else if (sel < 80) w.req_type = REQ_UPDATE;
            else if (sel < 86) w.req_type = REQ_STOP;
            else w.req_type = REQ_STOP_ALL;
        end
        return w;
    endfunction

    typedef struct {
        in_t w;
        logic chk;
        out_t exp0;
    } dir_row_t;

    dir_row_t dir_rows [$];

    function automatic out_t ev(logic [2:0] st, logic [1:0] ch, logic [31:0] t,
                                logic [2:0] pl, logic [2:0] am);
        out_t r;
        r = '0;
        r.status = st; r.event_channel = ch; r.event_time_ms = t;
        r.pin_levels = pl; r.active_mask = am; r.last = 1'b1;
        return r;
    endfunction

    function automatic void add_row(in_t w, logic chk, out_t e);
        dir_row_t r;
        r.w = w; r.chk = chk; r.exp0 = e;
        dir_rows.push_back(r);
    endfunction

    initial begin
        lim_dur = 32'd3600000; lim_hz = 16'd50;
        pwm_cnt = '0; pins = '0; active = '0;
        for (int k = 0; k < 3; k++) begin
            duty[k] = '0; c_bright[k] = '0; c_pulse[k] = 1'b0; c_start[k] = '0;
            c_dur[k] = '0; c_half[k] = '0; c_next[k] = '0; c_phase[k] = 1'b0;
        end
        t_ms = $urandom(); t_us = $urandom();

        // directed table; exp0 typed where obvious
        add_row(mk(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1, ev(ST_ACK, 0, 0, 3'b000, 3'b000));
        add_row(mk(REQ_START, 3, 0, 0, 0, 8'hff, 32'hffffffff, 0), 1,
                ev(ST_BAD_CH, 3, 32'hffffffff, 0, 0));
        add_row(mk(REQ_START, 1, 32'd3600001, 0, 0, 1, 5, 0), 1,
                ev(ST_BAD_DUR, 1, 5, 0, 0));
        add_row(mk(REQ_START, 2, 0, 1, 0, 1, 6, 0), 1, ev(ST_BAD_HZ, 2, 6, 0, 0));
        add_row(mk(REQ_START, 2, 0, 1, 16'd51, 1, 7, 0), 1, ev(ST_BAD_HZ, 2, 7, 0, 0));
        add_row(mk(REQ_STOP, 0, 0, 0, 0, 0, 8, 0), 1, ev(ST_ACK, 0, 0, 0, 0));
        add_row(mk(3'd7, 3, 32'hffffffff, 1, 16'hffff, 8'hff, 32'hffffffff, 32'hffffffff),
                1, ev(ST_ACK, 0, 0, 0, 0));
        add_row(mk(REQ_START, 0, 32'd3600000, 0, 16'hffff, 8'hff, 100, 0), 0, '0);
        add_row(mk(REQ_START, 1, 0, 1, 16'd50, 8'h80, 101, 32'hfffffff0), 0, '0);
        add_row(mk(REQ_START, 2, 10, 1, 16'd1, 0, 102, 1000), 0, '0);
        add_row(mk(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk(REQ_UPDATE, 0, 0, 0, 0, 0, 105, 32'h00002000), 0, '0);
        add_row(mk(REQ_UPDATE, 0, 0, 0, 0, 0, 112, 32'h00100000), 0, '0);
        add_row(mk(REQ_START, 0, 5, 1, 16'd50, 8'h01, 120, 0), 0, '0);
        add_row(mk(REQ_STOP, 3, 0, 0, 0, 0, 121, 0), 0, '0);
        add_row(mk(REQ_STOP, 1, 0, 0, 0, 0, 122, 0), 0, '0);
        add_row(mk(REQ_START, 1, 0, 0, 0, 8'h40, 123, 0), 0, '0);
        add_row(mk(REQ_START, 2, 0, 0, 0, 8'h20, 124, 0), 0, '0);
        add_row(mk(REQ_STOP_ALL, 0, 0, 0, 0, 0, 32'hfffffffe, 0), 0, '0);
        add_row(mk(REQ_STOP_ALL, 0, 0, 0, 0, 0, 1, 0), 0, '0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].chk) begin
                hold_off();
                while (led_events.size() != 0) @(posedge aclk);
                send_word(dir_rows[i].w);
                if (step_events.size() != 1 || step_events[0] !== dir_rows[i].exp0) begin
                    $error("directed row %0d: predictor disagrees with table", i);
                    errors++;
                end
            end else
                send_word(dir_rows[i].w);
        end

        // phases over the register settings, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_reg(CFG_MAX_DUR, 32'd2000); write_reg(CFG_MAX_HZ, 32'd1); end
                1: begin write_reg(CFG_MAX_DUR, 32'hffffffff);
                         write_reg(CFG_MAX_HZ, 32'h0000ffff); end
                2: begin write_reg(CFG_MAX_DUR, 32'd0); write_reg(CFG_MAX_HZ, 32'd30); end
                3: begin write_reg(CFG_MAX_DUR, $urandom_range(500, 5000));
                         write_reg(CFG_MAX_HZ, $urandom_range(2, 60)); end
                default: begin write_reg(CFG_MAX_DUR, 32'd3600000);
                               write_reg(CFG_MAX_HZ, 32'd50); end
            endcase
            for (int i = 0; i < 100; i++) send_word(rand_word());
        end

        hold_off();
        while (led_events.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Covered %0d request words, %0d result words (%0d led on, %0d led off).",
                 n_items, n_results, n_on, n_off);
        if (errors == 0 && led_events.size() == 0)
            $display("PASS timed_pulsing_pwm_led_cues");
        else
            $display("FAIL timed_pulsing_pwm_led_cues");
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL timed_pulsing_pwm_led_cues");
        $finish;
    end
endmodule

// File: files.f
rtl/tpl_pkg.sv
rtl/tpl_front.sv
rtl/tpl_div.sv
rtl/tpl_back.sv
rtl/timed_pulsing_pwm_led_cues.sv
tb/tb_timed_pulsing_pwm_led_cues.sv
